// ===== rtl/core/wsrq_pkg.sv =====
// ----------------------------------------------------------------------------
// wsrq_pkg
// Shared constants, codes and types of the work stealing run queue.
// ----------------------------------------------------------------------------
package wsrq_pkg;

   localparam int DEQUE_DEPTH = 64;
   localparam int STEAL_MAX   = 32;

   localparam int PTR_W     = $clog2(DEQUE_DEPTH);
   localparam int CNT_W     = $clog2(DEQUE_DEPTH + 1);
   localparam int DRAIN_MAX = (DEQUE_DEPTH / 2 > STEAL_MAX) ? DEQUE_DEPTH / 2 : STEAL_MAX;
   localparam int DRAIN_W   = $clog2(DRAIN_MAX + 1);

   localparam int TASK_W     = 16;
   localparam int OP_W       = 2;
   localparam int LIMIT_W    = 6;
   localparam int BACKLOG_W  = 16;
   localparam int POLLS_W    = 8;
   localparam int FILL_W     = 7;
   localparam int KIND_W     = 2;
   localparam int REASON_W   = 2;
   localparam int CALC_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POLLS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLOG_THR = 2'd1;

   localparam logic [POLLS_W-1:0]   MAX_POLLS_RST   = 8'd3;
   localparam logic [BACKLOG_W-1:0] BACKLOG_THR_RST = 16'd32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH, OP_PUSH_LIFO, OP_POP, OP_STEAL
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK, KIND_TASK, KIND_SPILL, KIND_STOLEN
   } kind_type;

   typedef enum logic [REASON_W-1:0] {
      GATE_NONE, GATE_BUDGET, GATE_BACKLOG
   } reason_type;

   // How a request finishes once its drain of oldest entries is done.
   typedef enum logic [1:0] {
      FIN_ACK, FIN_TASK, FIN_POP, FIN_NONE
   } fin_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DRAIN_RD, S_DRAIN_OUT, S_WRITE, S_POP_RD, S_FINAL
   } state_type;

   typedef struct packed {
      logic [DRAIN_W-1:0] drain;
      kind_type           drain_kind;
      reason_type         reason;
      logic               do_write;
      fin_type            fin;
      logic [TASK_W-1:0]  task_id;
      logic [CNT_W-1:0]   fill;
   } plan_type;

   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] sum);
      logic [PTR_W:0] res;
      res = sum;
      if (sum >= (PTR_W + 1)'(DEQUE_DEPTH)) begin
         res = sum - (PTR_W + 1)'(DEQUE_DEPTH);
      end
      return res[PTR_W-1:0];
   endfunction

endpackage

// ===== rtl/core/wsrq_ram.sv =====
// ----------------------------------------------------------------------------
// wsrq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wsrq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wsrq_plan.sv =====
// ----------------------------------------------------------------------------
// wsrq_plan
// LIFO slot state and request decode into a plan for the sequencer.
// ----------------------------------------------------------------------------
module wsrq_plan import wsrq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  op_type               op,
   input  logic [TASK_W-1:0]    task_id,
   input  logic [LIMIT_W-1:0]   steal_limit,
   input  logic                 inbox_pending,
   input  logic [BACKLOG_W-1:0] inject_backlog,
   input  logic [POLLS_W-1:0]   max_polls,
   input  logic [BACKLOG_W-1:0] backlog_thr,
   input  logic [CNT_W-1:0]     count,
   output plan_type             plan
);

   logic [TASK_W-1:0]  slot_task_ff,  slot_task_in;
   logic               slot_valid_ff, slot_valid_in;
   logic [POLLS_W-1:0] slot_hits_ff,  slot_hits_in;

   logic               full;
   logic               backlogged;
   logic               served;
   logic [CALC_W-1:0]  steal_n;
   logic [CNT_W-1:0]   half_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_task_ff  <= '0;
         slot_valid_ff <= 1'b0;
         slot_hits_ff  <= '0;
      end else begin
         slot_task_ff  <= slot_task_in;
         slot_valid_ff <= slot_valid_in;
         slot_hits_ff  <= slot_hits_in;
      end
   end

   always_comb begin
      full       = (count == CNT_W'(DEQUE_DEPTH));
      half_cnt   = CNT_W'(DEQUE_DEPTH / 2);
      backlogged = inbox_pending ||
                   ((inject_backlog != '0) && (inject_backlog >= backlog_thr));
      served     = slot_valid_ff && (slot_hits_ff < max_polls) && !backlogged;

      // Steal count: half the fill, capped by the global and the thief's limit, at least one.
      steal_n = CALC_W'(count >> 1);
      if (steal_n > CALC_W'(STEAL_MAX)) begin
         steal_n = CALC_W'(STEAL_MAX);
      end
      if (steal_n > CALC_W'(steal_limit)) begin
         steal_n = CALC_W'(steal_limit);
      end
      if (steal_n == '0) begin
         steal_n = CALC_W'(1);
      end

      plan            = '0;
      plan.drain_kind = KIND_SPILL;
      plan.reason     = GATE_NONE;
      plan.fin        = FIN_ACK;
      plan.fill       = count;

      slot_task_in  = slot_task_ff;
      slot_valid_in = slot_valid_ff;
      slot_hits_in  = slot_hits_ff;

      case (op)
         OP_PUSH, OP_PUSH_LIFO: begin
            if (op == OP_PUSH || slot_valid_ff) begin
               plan.do_write = 1'b1;
               plan.task_id  = (op == OP_PUSH) ? task_id : slot_task_ff;
               if (full) begin
                  plan.drain = DRAIN_W'(DEQUE_DEPTH / 2);
                  plan.fill  = count - half_cnt + CNT_W'(1);
               end else begin
                  plan.fill  = count + CNT_W'(1);
               end
            end
            if (accept && op == OP_PUSH_LIFO) begin
               slot_task_in  = task_id;
               slot_valid_in = 1'b1;
            end
         end
         OP_POP: begin
            if (slot_valid_ff) begin
               // A gated slot task is pushed and at once popped again as the
               // newest entry, so it never needs to be written to the ring.
               plan.fin     = FIN_TASK;
               plan.task_id = slot_task_ff;
               if (!served) begin
                  plan.reason = (slot_hits_ff >= max_polls) ? GATE_BUDGET : GATE_BACKLOG;
                  if (full) begin
                     plan.drain = DRAIN_W'(DEQUE_DEPTH / 2);
                     plan.fill  = count - half_cnt;
                  end
               end
            end else if (count != '0) begin
               plan.fin  = FIN_POP;
               plan.fill = count - CNT_W'(1);
            end
            if (accept) begin
               slot_valid_in = 1'b0;
               if (slot_valid_ff) begin
                  slot_task_in = '0;
               end
               slot_hits_in = served ? slot_hits_ff + POLLS_W'(1) : '0;
            end
         end
         OP_STEAL: begin
            plan.drain_kind = KIND_STOLEN;
            if (count != '0) begin
               plan.drain = DRAIN_W'(steal_n);
               plan.fin   = FIN_NONE;
               plan.fill  = count - CNT_W'(steal_n);
            end
         end
         default: begin
            plan.fin = FIN_ACK;
         end
      endcase
   end

endmodule

// ===== rtl/core/wsrq_seq.sv =====
// ----------------------------------------------------------------------------
// wsrq_seq
// Deque sequencer: ring pointers, ring memory accesses and the result register.
// ----------------------------------------------------------------------------
module wsrq_seq import wsrq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  plan_type           plan,
   output logic               idle,
   output logic [CNT_W-1:0]   count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [TASK_W-1:0]  rsp_out_task,
   output logic [REASON_W-1:0] rsp_gate_reason,
   output logic               rsp_last,
   output logic [FILL_W-1:0]  rsp_fill
);

   state_type          state_ff,  state_in;
   logic [PTR_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [DRAIN_W-1:0] left_ff,   left_in;
   kind_type           dkind_ff,  dkind_in;
   reason_type         reason_ff, reason_in;
   logic               write_ff,  write_in;
   fin_type            fin_ff,    fin_in;
   logic [TASK_W-1:0]  task_ff,   task_in;
   logic [CNT_W-1:0]   fill_ff,   fill_in;

   logic               rsp_valid_ff,  rsp_valid_in;
   kind_type           rsp_kind_ff,   rsp_kind_in;
   logic [TASK_W-1:0]  rsp_task_ff,   rsp_task_in;
   reason_type         rsp_reason_ff, rsp_reason_in;
   logic               rsp_last_ff,   rsp_last_in;
   logic [CNT_W-1:0]   rsp_fill_ff,   rsp_fill_in;

   logic               out_free;
   logic               rd_en, wr_en;
   logic [PTR_W-1:0]   rd_addr, wr_addr;
   logic [TASK_W-1:0]  rd_data;
   logic [PTR_W:0]     bottom_sum;
   state_type          after_drain;

   wsrq_ram #(
      .WIDTH (TASK_W),
      .DEPTH (DEQUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (task_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dkind_ff      <= dkind_in;
      reason_ff     <= reason_in;
      write_ff      <= write_in;
      fin_ff        <= fin_in;
      task_ff       <= task_in;
      fill_ff       <= fill_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      dkind_in  = dkind_ff;
      reason_in = reason_ff;
      write_in  = write_ff;
      fin_in    = fin_ff;
      task_in   = task_ff;
      fill_in   = fill_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_reason_in = rsp_reason_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fill_in   = rsp_fill_ff;

      out_free   = !rsp_valid_ff || !rsp_stall;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      rd_addr    = oldest_ff;
      bottom_sum = {1'b0, oldest_ff} + (PTR_W + 1)'(count_ff);
      wr_addr    = wrap_ptr(bottom_sum);

      if (write_ff) begin
         after_drain = S_WRITE;
      end else if (fin_ff == FIN_NONE) begin
         after_drain = S_IDLE;
      end else if (fin_ff == FIN_POP) begin
         after_drain = S_POP_RD;
      end else begin
         after_drain = S_FINAL;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               left_in   = plan.drain;
               dkind_in  = plan.drain_kind;
               reason_in = plan.reason;
               write_in  = plan.do_write;
               fin_in    = plan.fin;
               task_in   = plan.task_id;
               fill_in   = plan.fill;
               if (plan.drain != '0) begin
                  state_in = S_DRAIN_RD;
               end else if (plan.do_write) begin
                  state_in = S_WRITE;
               end else if (plan.fin == FIN_POP) begin
                  state_in = S_POP_RD;
               end else begin
                  state_in = S_FINAL;
               end
            end
         end
         S_DRAIN_RD: begin
            rd_en    = 1'b1;
            state_in = S_DRAIN_OUT;
         end
         S_DRAIN_OUT: begin
            // Read data holds until the next read, so a stall just waits here.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dkind_ff;
               rsp_task_in   = rd_data;
               rsp_reason_in = reason_ff;
               rsp_last_in   = (left_ff == DRAIN_W'(1)) && (fin_ff == FIN_NONE);
               rsp_fill_in   = fill_ff;
               oldest_in     = wrap_ptr({1'b0, oldest_ff} + (PTR_W + 1)'(1));
               count_in      = count_ff - CNT_W'(1);
               left_in       = left_ff - DRAIN_W'(1);
               state_in      = (left_ff == DRAIN_W'(1)) ? after_drain : S_DRAIN_RD;
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = S_FINAL;
         end
         S_POP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = wrap_ptr(bottom_sum - (PTR_W + 1)'(1));
            count_in = count_ff - CNT_W'(1);
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_reason_in = reason_ff;
               rsp_last_in   = 1'b1;
               rsp_fill_in   = fill_ff;
               case (fin_ff)
                  FIN_TASK: begin
                     rsp_kind_in = KIND_TASK;
                     rsp_task_in = task_ff;
                  end
                  FIN_POP: begin
                     rsp_kind_in = KIND_TASK;
                     rsp_task_in = rd_data;
                  end
                  default: begin
                     rsp_kind_in = KIND_ACK;
                     rsp_task_in = '0;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle            = (state_ff == S_IDLE);
   assign count           = count_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_task    = rsp_task_ff;
   assign rsp_gate_reason = rsp_reason_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_fill        = FILL_W'(rsp_fill_ff);

endmodule

// ===== rtl/core/work_stealing_run_queue_top.sv =====
// ----------------------------------------------------------------------------
// work_stealing_run_queue_top
// Per-worker run queue: bounded task deque in a ring memory plus a LIFO slot.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (req_*) carries one operation: push, LIFO push, pop or steal.
// Each request produces one or more result beats on rsp_*, the final one
// flagged by rsp_last; all beats of a request carry the fill after it.
// The queue takes one request at a time. A request without spill or steal
// passes through S_WRITE or S_POP_RD where needed to S_FINAL, which loads
// its final beat; the next request is taken once the sequencer is idle.
// Spilled and stolen entries come from the oldest end of the ring memory,
// each beat with one read state and one output load state in turn.
// A stalled result beat holds in the output register; the sequencer waits
// behind it and holds req_stall high until its final beat is loaded.
// After reset the deque and the slot are empty, max_lifo_polls is 3 and
// backlog_threshold is 32. The ring memory needs no clearing pass.
// The csr_* port always accepts; write it only while the queue is idle.
// ----------------------------------------------------------------------------
module work_stealing_run_queue_top import wsrq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [LIMIT_W-1:0]    req_steal_limit,
   input  logic                  req_inbox_pending,
   input  logic [BACKLOG_W-1:0]  req_inject_backlog,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [TASK_W-1:0]     rsp_out_task,
   output logic [REASON_W-1:0]   rsp_gate_reason,
   output logic                  rsp_last,
   output logic [FILL_W-1:0]     rsp_fill,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [POLLS_W-1:0]   max_polls_ff;
   logic [BACKLOG_W-1:0] backlog_thr_ff;
   logic                 accept;
   logic                 idle;
   logic [CNT_W-1:0]     count;
   plan_type             plan;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_polls_ff   <= MAX_POLLS_RST;
         backlog_thr_ff <= BACKLOG_THR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_POLLS:   max_polls_ff   <= csr_wdata[POLLS_W-1:0];
            CSR_BACKLOG_THR: backlog_thr_ff <= csr_wdata[BACKLOG_W-1:0];
            default: begin
               max_polls_ff <= max_polls_ff;
            end
         endcase
      end
   end

   wsrq_plan u_plan (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (op_type'(req_opcode)),
      .task_id        (req_task_id),
      .steal_limit    (req_steal_limit),
      .inbox_pending  (req_inbox_pending),
      .inject_backlog (req_inject_backlog),
      .max_polls      (max_polls_ff),
      .backlog_thr    (backlog_thr_ff),
      .count          (count),
      .plan           (plan)
   );

   wsrq_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .plan            (plan),
      .idle            (idle),
      .count           (count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_task    (rsp_out_task),
      .rsp_gate_reason (rsp_gate_reason),
      .rsp_last        (rsp_last),
      .rsp_fill        (rsp_fill)
   );

   // The deque never reports more entries than the ring holds.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill <= FILL_W'(DEQUE_DEPTH)))
      else $error("result fill exceeds deque depth");

   // An empty or ack beat always closes its request and carries no task.
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ACK) |-> (rsp_last && rsp_out_task == '0))
      else $error("ack beat is not final or carries a task");

   // While a non-final beat is pending, the queue is still busy with its request.
   a_busy_mid_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request accepted in the middle of a burst");

   // Stolen beats never carry a gate reason.
   a_steal_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STOLEN) |-> (rsp_gate_reason == GATE_NONE))
      else $error("stolen beat carries a gate reason");

endmodule

// ===== tb/sv/tb_work_stealing_run_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_work_stealing_run_queue_top
// Self-checking bench for the per-worker run queue with its LIFO slot.
// Requests go in as bursts with random gaps while the response side stalls
// on a changing pattern. A local model of the deque and the slot predicts
// every response beat, and each beat is checked field by field in order.
// Directed cases cover empty queues, slot gating and full-deque spills; then
// random traffic runs under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_work_stealing_run_queue_top;
   import wsrq_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      kind_type          kind;
      logic [TASK_W-1:0] tid;
      reason_type        reason;
      logic              last;
      logic [FILL_W-1:0] fill;
   } beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode = '0;
   logic [TASK_W-1:0]     req_task_id = '0;
   logic [LIMIT_W-1:0]    req_steal_limit = '0;
   logic                  req_inbox_pending = 1'b0;
   logic [BACKLOG_W-1:0]  req_inject_backlog = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [TASK_W-1:0]     rsp_out_task;
   logic [REASON_W-1:0]   rsp_gate_reason;
   logic                  rsp_last;
   logic [FILL_W-1:0]     rsp_fill;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   work_stealing_run_queue_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_task_id        (req_task_id),
      .req_steal_limit    (req_steal_limit),
      .req_inbox_pending  (req_inbox_pending),
      .req_inject_backlog (req_inject_backlog),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_task       (rsp_out_task),
      .rsp_gate_reason    (rsp_gate_reason),
      .rsp_last           (rsp_last),
      .rsp_fill           (rsp_fill),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // Local copy of the queue state and the registers.
   logic [TASK_W-1:0]    m_ring [DEQUE_DEPTH];
   int                   m_head = 0;
   int                   m_count = 0;
   logic [TASK_W-1:0]    m_slot = '0;
   logic                 m_slot_valid = 1'b0;
   logic [POLLS_W-1:0]   m_hits = '0;
   logic [POLLS_W-1:0]   cfg_polls = MAX_POLLS_RST;
   logic [BACKLOG_W-1:0] cfg_thr = BACKLOG_THR_RST;

   beat_type step_beats[$];
   beat_type due_beats[$];
   int       fail_count = 0;
   int       burst_left = 0;
   int       cycle_count = 0;

   function automatic void add_beat(kind_type k, logic [TASK_W-1:0] t, reason_type r);
      beat_type b;
      b.kind = k;
      b.tid = t;
      b.reason = r;
      b.last = 1'b0;
      b.fill = '0;
      step_beats.push_back(b);
   endfunction

   function automatic logic [TASK_W-1:0] take_oldest();
      logic [TASK_W-1:0] t;
      t = m_ring[m_head];
      m_head = (m_head + 1) % DEQUE_DEPTH;
      m_count--;
      return t;
   endfunction

   // A full deque gives up its oldest half before the new task lands.
   function automatic void land_task(logic [TASK_W-1:0] t, reason_type r);
      if (m_count >= DEQUE_DEPTH) begin
         for (int k = 0; k < DEQUE_DEPTH / 2 && m_count > 0; k++) begin
            add_beat(KIND_SPILL, take_oldest(), r);
         end
      end
      m_ring[(m_head + m_count) % DEQUE_DEPTH] = t;
      m_count++;
   endfunction

   function automatic void compute_response_beats(op_type op, logic [TASK_W-1:0] tid,
         logic [LIMIT_W-1:0] lim, logic inbox, logic [BACKLOG_W-1:0] backlog);
      reason_type        why;
      logic              served;
      logic              had;
      logic [TASK_W-1:0] held;
      int                n;
      int                idx;
      step_beats.delete();
      case (op)
         OP_PUSH: begin
            land_task(tid, GATE_NONE);
            add_beat(KIND_ACK, '0, GATE_NONE);
         end
         OP_PUSH_LIFO: begin
            had = m_slot_valid;
            held = m_slot;
            m_slot = tid;
            m_slot_valid = 1'b1;
            if (had) begin
               land_task(held, GATE_NONE);
            end
            add_beat(KIND_ACK, '0, GATE_NONE);
         end
         OP_POP: begin
            why = GATE_NONE;
            served = 1'b0;
            if (m_slot_valid) begin
               if (m_hits >= cfg_polls) begin
                  why = GATE_BUDGET;
               end else if (inbox || (backlog != 0 && backlog >= cfg_thr)) begin
                  why = GATE_BACKLOG;
               end
               held = m_slot;
               m_slot_valid = 1'b0;
               m_slot = '0;
               if (why == GATE_NONE) begin
                  add_beat(KIND_TASK, held, GATE_NONE);
                  m_hits = m_hits + 1'b1;
                  served = 1'b1;
               end else begin
                  land_task(held, why);
               end
            end
            if (!served) begin
               m_hits = '0;
               if (m_count > 0) begin
                  idx = (m_head + m_count - 1) % DEQUE_DEPTH;
                  m_count--;
                  add_beat(KIND_TASK, m_ring[idx], why);
               end else begin
                  add_beat(KIND_ACK, '0, why);
               end
            end
         end
         default: begin
            n = m_count / 2;
            if (n > STEAL_MAX) n = STEAL_MAX;
            if (n > lim) n = lim;
            if (n == 0) n = 1;
            for (int i = 0; i < n && m_count > 0; i++) begin
               add_beat(KIND_STOLEN, take_oldest(), GATE_NONE);
            end
            if (step_beats.size() == 0) begin
               add_beat(KIND_ACK, '0, GATE_NONE);
            end
         end
      endcase
      foreach (step_beats[i]) begin
         step_beats[i].fill = FILL_W'(m_count);
         step_beats[i].last = (i == step_beats.size() - 1);
         due_beats.push_back(step_beats[i]);
      end
   endfunction

   // Called at a rising edge; returns at the edge that accepts the beat.
   task automatic issue_request(op_type op, logic [TASK_W-1:0] tid, logic [LIMIT_W-1:0] lim,
         logic inbox, logic [BACKLOG_W-1:0] backlog);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_id <= tid;
      req_steal_limit <= lim;
      req_inbox_pending <= inbox;
      req_inject_backlog <= backlog;
      burst_left--;
      do @(posedge clock); while (req_stall);
      compute_response_beats(op, tid, lim, inbox, backlog);
   endtask

   task automatic push_task(logic [TASK_W-1:0] tid);
      issue_request(OP_PUSH, tid, LIMIT_W'($urandom), 1'($urandom), BACKLOG_W'($urandom));
   endtask

   task automatic lifo_task(logic [TASK_W-1:0] tid);
      issue_request(OP_PUSH_LIFO, tid, LIMIT_W'($urandom), 1'($urandom), BACKLOG_W'($urandom));
   endtask

   task automatic pop_task(logic inbox, logic [BACKLOG_W-1:0] backlog);
      issue_request(OP_POP, TASK_W'($urandom), LIMIT_W'($urandom), inbox, backlog);
   endtask

   task automatic steal_task(logic [LIMIT_W-1:0] lim);
      issue_request(OP_STEAL, TASK_W'($urandom), lim, 1'($urandom), BACKLOG_W'($urandom));
   endtask

   task automatic issue_random_request(int bias);
      int                   pick;
      int                   rest;
      logic [BACKLOG_W-1:0] backlog;
      op_type               op;
      pick = $urandom_range(0, 99);
      rest = 100 - bias;
      if (pick < bias) op = OP_PUSH;
      else if (pick < bias + rest * 2 / 5) op = OP_PUSH_LIFO;
      else if (pick < bias + rest * 4 / 5) op = OP_POP;
      else op = OP_STEAL;
      // Keep the backlog near the threshold often so both sides of it are hit.
      case ($urandom_range(0, 5))
         0: backlog = '0;
         1: backlog = cfg_thr - 1'b1;
         2: backlog = cfg_thr;
         3: backlog = cfg_thr + BACKLOG_W'($urandom_range(1, 100));
         4: backlog = '1;
         default: backlog = BACKLOG_W'($urandom);
      endcase
      issue_request(op, TASK_W'($urandom), LIMIT_W'($urandom_range(0, 63)),
                    ($urandom_range(0, 3) == 0), backlog);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_POLLS) cfg_polls = data[POLLS_W-1:0];
      else if (idx == CSR_BACKLOG_THR) cfg_thr = data;
      @(posedge clock);
   endtask

   task automatic fill_deque();
      while (m_count < DEQUE_DEPTH) push_task(TASK_W'($urandom));
   endtask

   task automatic run_phase(logic [POLLS_W-1:0] polls, logic [BACKLOG_W-1:0] thr,
         int count, int bias);
      logic [7:0] junk;
      junk = $urandom;
      wait_drained();
      write_csr(CSR_MAX_POLLS, {junk, polls});
      write_csr(CSR_BACKLOG_THR, thr);
      repeat (count) issue_random_request(bias);
   endtask

   task automatic test_empty_queue();
      pop_task(1'b1, '1);
      steal_task('0);
      steal_task('1);
   endtask

   task automatic test_push_pop_extremes();
      push_task(16'h0000);
      push_task(16'hFFFF);
      pop_task(1'b1, '1);
      pop_task(1'b0, '0);
   endtask

   // With the reset budget of three, the fourth slot pop in a row is gated.
   task automatic test_lifo_slot();
      lifo_task(16'h1234);
      lifo_task(16'hABCD);
      pop_task(1'b0, '0);
      lifo_task(16'h5A5A);
      pop_task(1'b0, '0);
      lifo_task(16'hA5A5);
      pop_task(1'b0, '0);
      lifo_task(16'h0F0F);
      pop_task(1'b0, '0);
      lifo_task(16'hF0F0);
      pop_task(1'b1, '0);
      lifo_task(16'h00FF);
      pop_task(1'b0, BACKLOG_THR_RST);
   endtask

   task automatic test_steal_counts();
      repeat (4) push_task(TASK_W'($urandom));
      steal_task('0);
      steal_task('1);
      steal_task(6'd1);
   endtask

   task automatic test_full_deque_spill();
      fill_deque();
      push_task(TASK_W'($urandom));
      fill_deque();
      steal_task('1);
      fill_deque();
      lifo_task(TASK_W'($urandom));
      lifo_task(TASK_W'($urandom));
      fill_deque();
      // The slot flush on a gated pop spills with the gate reason attached.
      pop_task(1'b1, '0);
   endtask

   task automatic test_config_extremes();
      wait_drained();
      write_csr(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_3, CSR_DATA_W'($urandom));
      run_phase(8'd0, 16'd1, 48, 45);
      run_phase(8'd255, 16'hFFFF, 48, 40);
      run_phase(POLLS_W'($urandom_range(1, 8)), BACKLOG_W'($urandom_range(1, 65535)), 48, 60);
      run_phase(MAX_POLLS_RST, BACKLOG_THR_RST, 48, 35);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Response checker and stall pattern.
   int   stall_mode = 0;
   int   stall_run = 0;
   logic stall_hold = 1'b0;
   int   stall_clock = 0;

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_beats.size() == 0) begin
            $error("unexpected response beat: kind %0d task %0d", rsp_kind, rsp_out_task);
            fail_count++;
         end else begin
            want = due_beats.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("out_task", want.tid, rsp_out_task);
            check_field("gate_reason", want.reason, rsp_gate_reason);
            check_field("last", want.last, rsp_last);
            check_field("fill", want.fill, rsp_fill);
         end
      end
      stall_clock++;
      if (stall_clock % 200 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run == 0) begin
               stall_hold = !stall_hold;
               stall_run = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 4);
            end
            stall_run--;
            rsp_stall <= stall_hold;
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_push_pop_extremes();
      test_lifo_slot();
      test_steal_counts();
      test_full_deque_spill();
      test_config_extremes();
      wait_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/wsrq_pkg.sv
rtl/core/wsrq_ram.sv
rtl/core/wsrq_plan.sv
rtl/core/wsrq_seq.sv
rtl/core/work_stealing_run_queue_top.sv
tb/sv/tb_work_stealing_run_queue_top.sv
